[hdl/spring_damper_force_top_macros.svh]
// Assertion shorthands shared by the checker.
`ifndef SPRING_DAMPER_FORCE_TOP_MACROS_SVH
`define SPRING_DAMPER_FORCE_TOP_MACROS_SVH

// Same-cycle implication, ignored while reset is asserted.
`define SDF_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("spring damper force check failed");

// Next-cycle implication, ignored while reset is asserted.
`define SDF_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("spring damper force check failed");

// Next-cycle implication that also holds across reset.
`define SDF_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("spring damper force check failed");

`endif

[hdl/sdf_pkg.sv]
package sdf_pkg;

    localparam int DATA_W        = 32;
    localparam int NUM_AXES      = 3;
    localparam int FRAC_BITS_DEF = 16;
    localparam int ROOT_STAGES   = 32;

    typedef logic signed [DATA_W-1:0] sword_t;
    typedef logic [DATA_W-1:0]        uword_t;

    // Per-spring payload while the length is being found.
    typedef struct packed {
        sword_t [NUM_AXES-1:0] d;
        sword_t [NUM_AXES-1:0] v;
        uword_t                k;
        uword_t                r;
        uword_t                c;
    } pass_t;

    // What the later stages still need once the direction is known.
    typedef struct packed {
        sword_t [NUM_AXES-1:0] v;
        uword_t                k;
        uword_t                r;
        uword_t                c;
    } tail_t;

    function automatic uword_t mag32(input sword_t x);
        return x[DATA_W-1] ? uword_t'(-x) : uword_t'(x);
    endfunction

endpackage

[hdl/spring_damper_force_top.sv]
// Damped spring force pipeline, Q16.16 at the default FRAC_BITS. One spring enters per clock
// on the s_ side unless the pipeline holds, and its force on end A leaves on the m_ side;
// end B takes the negated force. The square root resolves one root bit per stage over 32
// stages, and the three direction dividers resolve one quotient bit per stage over
// FRAC_BITS + 1 stages. When a result waits on m_tready the whole pipeline holds, and it
// resumes without losing or repeating a transaction. Springs no longer than 1e-6 give zero
// force with applied low; saturated reports a force component clamped to 32 bits.
module spring_damper_force_top
    import sdf_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    // delta_x, delta_y, delta_z, rel_vel_x, rel_vel_y, rel_vel_z, stiffness, rest_length, damping
    input  logic [9*DATA_W-1:0]       s_tdata,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    // force_x, force_y, force_z
    output logic [3*DATA_W-1:0]       m_tdata,
    // applied, saturated
    output logic [1:0]                m_tuser
);

    localparam int NUMW  = DATA_W + FRAC_BITS;
    localparam int QW    = FRAC_BITS + 1;
    localparam int UW    = QW + 1;
    localparam int PW    = DATA_W + UW;
    localparam int DW    = PW + 2;
    localparam int VW    = DW - 1 - FRAC_BITS;
    localparam int LRW   = DATA_W + 2;
    localparam int SPW   = 2 * DATA_W + 1;
    localparam int SW    = SPW - FRAC_BITS;
    localparam int DPW   = VW + DATA_W;
    localparam int DMW   = DPW - FRAC_BITS;
    localparam int TW    = DMW + 2;
    localparam int TMW   = TW - 1;
    localparam int HIW   = TMW - DATA_W;
    localparam int FPW   = TMW + QW;
    localparam int FMW   = FPW - FRAC_BITS;
    localparam int DIVST = QW;
    localparam int NST   = 3 + ROOT_STAGES + DIVST + 10;
    localparam logic [DATA_W-1:0] LEN_MIN = DATA_W'((2**FRAC_BITS + 500000) / 1000000);
    localparam logic [FMW-1:0] POS_MAX = FMW'(32'h7FFF_FFFF);
    localparam logic [FMW-1:0] NEG_MAX = FMW'(32'h8000_0000);

    logic en;
    logic [NST-1:0] vld_reg;

    assign en       = !vld_reg[NST-1] || m_tready;
    assign s_tready = en;
    assign m_tvalid = vld_reg[NST-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[NST-2:0], s_tvalid};
        end
    end

    // Input, squares and their sum.
    pass_t in_reg, p1_pass_reg, p2_pass_reg;
    logic [2*DATA_W-1:0] sqm_reg [NUM_AXES];
    logic [2*DATA_W-1:0] sum_reg;
    pass_t in_next;

    always_comb begin
        in_next.d[0] = s_tdata[0*DATA_W +: DATA_W];
        in_next.d[1] = s_tdata[1*DATA_W +: DATA_W];
        in_next.d[2] = s_tdata[2*DATA_W +: DATA_W];
        in_next.v[0] = s_tdata[3*DATA_W +: DATA_W];
        in_next.v[1] = s_tdata[4*DATA_W +: DATA_W];
        in_next.v[2] = s_tdata[5*DATA_W +: DATA_W];
        in_next.k    = s_tdata[6*DATA_W +: DATA_W];
        in_next.r    = s_tdata[7*DATA_W +: DATA_W];
        in_next.c    = s_tdata[8*DATA_W +: DATA_W];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            in_reg <= in_next;
            for (int i = 0; i < NUM_AXES; i++) begin
                sqm_reg[i] <= (2*DATA_W)'(mag32(in_reg.d[i])) * (2*DATA_W)'(mag32(in_reg.d[i]));
            end
            p1_pass_reg <= in_reg;
            sum_reg     <= sqm_reg[0] + sqm_reg[1] + sqm_reg[2];
            p2_pass_reg <= p1_pass_reg;
        end
    end

    // Square root: one root bit per stage, most significant first.
    logic [2*DATA_W-1:0] rs_rem_reg  [ROOT_STAGES];
    logic [2*DATA_W-1:0] rs_rem_next [ROOT_STAGES];
    logic [DATA_W-1:0]   rs_root_reg [ROOT_STAGES];
    logic [DATA_W-1:0]   rs_root_next[ROOT_STAGES];
    pass_t               rs_pass_reg [ROOT_STAGES];

    always_comb begin
        logic [2*DATA_W-1:0] rem_in;
        logic [2*DATA_W-1:0] trial;
        logic [DATA_W-1:0]   root_in;
        int                  b;
        for (int s = 0; s < ROOT_STAGES; s++) begin
            b       = ROOT_STAGES - 1 - s;
            rem_in  = (s == 0) ? sum_reg : rs_rem_reg[(s == 0) ? 0 : s-1];
            root_in = (s == 0) ? '0 : rs_root_reg[(s == 0) ? 0 : s-1];
            // (root + 2^b)^2 - root^2 with root holding only the bits above b.
            trial = ((2*DATA_W)'(root_in) << (b + 1)) + ((2*DATA_W)'(1) << (2 * b));
            if (rem_in >= trial) begin
                rs_rem_next[s]  = rem_in - trial;
                rs_root_next[s] = root_in | (DATA_W'(1) << b);
            end else begin
                rs_rem_next[s]  = rem_in;
                rs_root_next[s] = root_in;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int s = 0; s < ROOT_STAGES; s++) begin
                rs_rem_reg[s]  <= rs_rem_next[s];
                rs_root_reg[s] <= rs_root_next[s];
                rs_pass_reg[s] <= (s == 0) ? p2_pass_reg : rs_pass_reg[(s == 0) ? 0 : s-1];
            end
        end
    end

    // Direction: |d_i| * 2^F / length, one quotient bit per stage in each lane.
    logic [NUMW-1:0]   dv_rem_reg  [DIVST][NUM_AXES];
    logic [NUMW-1:0]   dv_rem_next [DIVST][NUM_AXES];
    logic [QW-1:0]     dv_q_reg    [DIVST][NUM_AXES];
    logic [QW-1:0]     dv_q_next   [DIVST][NUM_AXES];
    logic              dv_neg_reg  [DIVST][NUM_AXES];
    logic [DATA_W-1:0] dv_len_reg  [DIVST];
    logic              dv_app_reg  [DIVST];
    tail_t             dv_tail_reg [DIVST];
    pass_t             rs_last;
    tail_t             rs_tail;

    assign rs_last      = rs_pass_reg[ROOT_STAGES-1];
    assign rs_tail.v    = rs_last.v;
    assign rs_tail.k    = rs_last.k;
    assign rs_tail.r    = rs_last.r;
    assign rs_tail.c    = rs_last.c;

    always_comb begin
        logic [NUMW-1:0]   rem_in;
        logic [NUMW-1:0]   cmp;
        logic [QW-1:0]     q_in;
        logic [DATA_W-1:0] len_in;
        int                j;
        for (int s = 0; s < DIVST; s++) begin
            j      = FRAC_BITS - s;
            len_in = (s == 0) ? rs_root_reg[ROOT_STAGES-1] : dv_len_reg[(s == 0) ? 0 : s-1];
            cmp    = NUMW'(len_in) << j;
            for (int i = 0; i < NUM_AXES; i++) begin
                rem_in = (s == 0) ? (NUMW'(mag32(rs_last.d[i])) << FRAC_BITS)
                                  : dv_rem_reg[(s == 0) ? 0 : s-1][i];
                q_in   = (s == 0) ? '0 : dv_q_reg[(s == 0) ? 0 : s-1][i];
                if (rem_in >= cmp) begin
                    dv_rem_next[s][i] = rem_in - cmp;
                    dv_q_next[s][i]   = q_in | (QW'(1) << j);
                end else begin
                    dv_rem_next[s][i] = rem_in;
                    dv_q_next[s][i]   = q_in;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int s = 0; s < DIVST; s++) begin
                for (int i = 0; i < NUM_AXES; i++) begin
                    dv_rem_reg[s][i] <= dv_rem_next[s][i];
                    dv_q_reg[s][i]   <= dv_q_next[s][i];
                    dv_neg_reg[s][i] <= (s == 0) ? rs_last.d[i][DATA_W-1]
                                                 : dv_neg_reg[(s == 0) ? 0 : s-1][i];
                end
                if (s == 0) begin
                    dv_len_reg[s]  <= rs_root_reg[ROOT_STAGES-1];
                    dv_app_reg[s]  <= rs_root_reg[ROOT_STAGES-1] > LEN_MIN;
                    dv_tail_reg[s] <= rs_tail;
                end else begin
                    dv_len_reg[s]  <= dv_len_reg[s-1];
                    dv_app_reg[s]  <= dv_app_reg[s-1];
                    dv_tail_reg[s] <= dv_tail_reg[s-1];
                end
            end
        end
    end

    // Force arithmetic.
    logic signed [UW-1:0]  p0_u_reg    [NUM_AXES];
    logic [QW-1:0]         p0_umag_reg [NUM_AXES];
    logic                  p0_uneg_reg [NUM_AXES];
    logic [DATA_W:0]       p0_lrmag_reg;
    logic                  p0_lrneg_reg;
    logic                  p0_app_reg;
    tail_t                 p0_tail_reg;
    logic signed [LRW-1:0] lr;

    logic signed [PW-1:0]  p1_dp_reg   [NUM_AXES];
    logic [SPW-1:0]        p1_sprod_reg;
    logic                  p1_sneg_reg;
    logic [DATA_W-1:0]     p1_c_reg;
    logic [QW-1:0]         p1_umag_reg [NUM_AXES];
    logic                  p1_uneg_reg [NUM_AXES];
    logic                  p1_app_reg;

    logic signed [DW-1:0]  p2_dot_reg;
    logic [SW-1:0]         p2_spring_reg;
    logic                  p2_sneg_reg;
    logic [DATA_W-1:0]     p2_c_reg;
    logic [QW-1:0]         p2_umag_reg [NUM_AXES];
    logic                  p2_uneg_reg [NUM_AXES];
    logic                  p2_app_reg;

    logic [VW-1:0]         p3_vmag_reg;
    logic                  p3_vneg_reg;
    logic [SW-1:0]         p3_spring_reg;
    logic                  p3_sneg_reg;
    logic [DATA_W-1:0]     p3_c_reg;
    logic [QW-1:0]         p3_umag_reg [NUM_AXES];
    logic                  p3_uneg_reg [NUM_AXES];
    logic                  p3_app_reg;

    logic [DPW-1:0]        p4_dprod_reg;
    logic                  p4_vneg_reg;
    logic [SW-1:0]         p4_spring_reg;
    logic                  p4_sneg_reg;
    logic [QW-1:0]         p4_umag_reg [NUM_AXES];
    logic                  p4_uneg_reg [NUM_AXES];
    logic                  p4_app_reg;

    logic signed [TW-1:0]  p5_total_reg;
    logic [QW-1:0]         p5_umag_reg [NUM_AXES];
    logic                  p5_uneg_reg [NUM_AXES];
    logic                  p5_app_reg;
    logic signed [TW-1:0]  sp_s, dm_s;

    logic [TMW-1:0]        p6_tmag_reg;
    logic                  p6_tneg_reg;
    logic [QW-1:0]         p6_umag_reg [NUM_AXES];
    logic                  p6_uneg_reg [NUM_AXES];
    logic                  p6_app_reg;

    logic [DATA_W+QW-1:0]  p7_plo_reg  [NUM_AXES];
    logic [HIW+QW-1:0]     p7_phi_reg  [NUM_AXES];
    logic                  p7_fneg_reg [NUM_AXES];
    logic                  p7_app_reg;

    logic [FMW-1:0]        p8_fmag_reg [NUM_AXES];
    logic                  p8_fneg_reg [NUM_AXES];
    logic                  p8_app_reg;

    logic [DATA_W-1:0]     out_f_reg   [NUM_AXES];
    logic                  out_app_reg;
    logic                  out_sat_reg;
    logic [DATA_W-1:0]     out_f_next  [NUM_AXES];
    logic                  out_sat_next;

    assign lr = $signed({2'b00, dv_len_reg[DIVST-1]}) - $signed({2'b00, dv_tail_reg[DIVST-1].r});

    always_comb begin
        sp_s = $signed(TW'(p4_spring_reg));
        dm_s = $signed(TW'(p4_dprod_reg >> FRAC_BITS));
        if (p4_sneg_reg) begin
            sp_s = -sp_s;
        end
        if (p4_vneg_reg) begin
            dm_s = -dm_s;
        end
    end

    // Clamp each component to 32 bits; the magnitude keeps its sign apart until here.
    always_comb begin
        out_sat_next = 1'b0;
        for (int i = 0; i < NUM_AXES; i++) begin
            if (p8_fneg_reg[i]) begin
                if (p8_fmag_reg[i] > NEG_MAX) begin
                    out_f_next[i] = 32'h8000_0000;
                    out_sat_next  = 1'b1;
                end else begin
                    out_f_next[i] = DATA_W'(-p8_fmag_reg[i]);
                end
            end else begin
                if (p8_fmag_reg[i] > POS_MAX) begin
                    out_f_next[i] = 32'h7FFF_FFFF;
                    out_sat_next  = 1'b1;
                end else begin
                    out_f_next[i] = DATA_W'(p8_fmag_reg[i]);
                end
            end
        end
        if (!p8_app_reg) begin
            for (int i = 0; i < NUM_AXES; i++) begin
                out_f_next[i] = '0;
            end
            out_sat_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            // Signed unit direction and the stretch of the spring.
            for (int i = 0; i < NUM_AXES; i++) begin
                p0_umag_reg[i] <= dv_q_reg[DIVST-1][i];
                p0_uneg_reg[i] <= dv_neg_reg[DIVST-1][i];
                p0_u_reg[i]    <= dv_neg_reg[DIVST-1][i] ? -$signed({1'b0, dv_q_reg[DIVST-1][i]})
                                                         : $signed({1'b0, dv_q_reg[DIVST-1][i]});
            end
            p0_lrneg_reg <= lr[LRW-1];
            p0_lrmag_reg <= lr[LRW-1] ? (DATA_W+1)'(-lr) : (DATA_W+1)'(lr);
            p0_app_reg   <= dv_app_reg[DIVST-1];
            p0_tail_reg  <= dv_tail_reg[DIVST-1];

            // Velocity products and the spring product.
            for (int i = 0; i < NUM_AXES; i++) begin
                p1_dp_reg[i]   <= PW'($signed(p0_tail_reg.v[i])) * PW'(p0_u_reg[i]);
                p1_umag_reg[i] <= p0_umag_reg[i];
                p1_uneg_reg[i] <= p0_uneg_reg[i];
            end
            p1_sprod_reg <= SPW'(p0_lrmag_reg) * SPW'(p0_tail_reg.k);
            p1_sneg_reg  <= p0_lrneg_reg;
            p1_c_reg     <= p0_tail_reg.c;
            p1_app_reg   <= p0_app_reg;

            p2_dot_reg    <= DW'(p1_dp_reg[0]) + DW'(p1_dp_reg[1]) + DW'(p1_dp_reg[2]);
            p2_spring_reg <= SW'(p1_sprod_reg >> FRAC_BITS);
            p2_sneg_reg   <= p1_sneg_reg;
            p2_c_reg      <= p1_c_reg;
            p2_umag_reg   <= p1_umag_reg;
            p2_uneg_reg   <= p1_uneg_reg;
            p2_app_reg    <= p1_app_reg;

            p3_vneg_reg   <= p2_dot_reg[DW-1];
            p3_vmag_reg   <= VW'((p2_dot_reg[DW-1] ? DW'(-p2_dot_reg) : DW'(p2_dot_reg))
                                 >> FRAC_BITS);
            p3_spring_reg <= p2_spring_reg;
            p3_sneg_reg   <= p2_sneg_reg;
            p3_c_reg      <= p2_c_reg;
            p3_umag_reg   <= p2_umag_reg;
            p3_uneg_reg   <= p2_uneg_reg;
            p3_app_reg    <= p2_app_reg;

            p4_dprod_reg  <= DPW'(p3_vmag_reg) * DPW'(p3_c_reg);
            p4_vneg_reg   <= p3_vneg_reg;
            p4_spring_reg <= p3_spring_reg;
            p4_sneg_reg   <= p3_sneg_reg;
            p4_umag_reg   <= p3_umag_reg;
            p4_uneg_reg   <= p3_uneg_reg;
            p4_app_reg    <= p3_app_reg;

            p5_total_reg <= sp_s + dm_s;
            p5_umag_reg  <= p4_umag_reg;
            p5_uneg_reg  <= p4_uneg_reg;
            p5_app_reg   <= p4_app_reg;

            p6_tneg_reg <= p5_total_reg[TW-1];
            p6_tmag_reg <= p5_total_reg[TW-1] ? TMW'(-p5_total_reg) : TMW'(p5_total_reg);
            p6_umag_reg <= p5_umag_reg;
            p6_uneg_reg <= p5_uneg_reg;
            p6_app_reg  <= p5_app_reg;

            // The wide total times the direction, split into two narrow products.
            for (int i = 0; i < NUM_AXES; i++) begin
                p7_plo_reg[i]  <= (DATA_W+QW)'(p6_tmag_reg[DATA_W-1:0]) * (DATA_W+QW)'(p6_umag_reg[i]);
                p7_phi_reg[i]  <= (HIW+QW)'(p6_tmag_reg[TMW-1:DATA_W]) * (HIW+QW)'(p6_umag_reg[i]);
                p7_fneg_reg[i] <= p6_tneg_reg ^ p6_uneg_reg[i];
            end
            p7_app_reg <= p6_app_reg;

            for (int i = 0; i < NUM_AXES; i++) begin
                p8_fmag_reg[i] <= FMW'(((FPW'(p7_phi_reg[i]) << DATA_W) + FPW'(p7_plo_reg[i]))
                                       >> FRAC_BITS);
                p8_fneg_reg[i] <= p7_fneg_reg[i];
            end
            p8_app_reg <= p7_app_reg;

            out_f_reg   <= out_f_next;
            out_sat_reg <= out_sat_next;
            out_app_reg <= p8_app_reg;
        end
    end

    assign m_tdata = {out_f_reg[2], out_f_reg[1], out_f_reg[0]};
    assign m_tuser = {out_sat_reg, out_app_reg};

endmodule

[hdl/sdf_checker.sv]
`include "spring_damper_force_top_macros.svh"

module sdf_checker
    import sdf_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [3*DATA_W-1:0]   m_tdata,
    input logic [1:0]            m_tuser
);

    logic [DATA_W-1:0] fx, fy, fz;
    logic              applied, saturated, fx_lim, fy_lim, fz_lim;

    assign fx        = m_tdata[0*DATA_W +: DATA_W];
    assign fy        = m_tdata[1*DATA_W +: DATA_W];
    assign fz        = m_tdata[2*DATA_W +: DATA_W];
    assign applied   = m_tuser[0];
    assign saturated = m_tuser[1];
    assign fx_lim    = (fx == 32'h7FFF_FFFF) || (fx == 32'h8000_0000);
    assign fy_lim    = (fy == 32'h7FFF_FFFF) || (fy == 32'h8000_0000);
    assign fz_lim    = (fz == 32'h7FFF_FFFF) || (fz == 32'h8000_0000);

    // A held result keeps its payload.
    `SDF_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready,
                     m_tvalid && $stable(m_tdata) && $stable(m_tuser))

    // A short spring carries no force and never reports a clamp.
    `SDF_ASSERT_NOW(a_short_zero, aclk, aresetn, m_tvalid && !applied,
                    (m_tdata == '0) && !saturated)

    // A clamp leaves at least one component at a range limit.
    `SDF_ASSERT_NOW(a_sat_limit, aclk, aresetn, m_tvalid && saturated,
                    fx_lim || fy_lim || fz_lim)

    // The pipeline is empty right after reset.
    `SDF_ASSERT_NEXT_ALWAYS(a_reset_empty, aclk, !aresetn, !m_tvalid)

endmodule

bind spring_damper_force_top sdf_checker u_sdf_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

[dv/testbench.sv]
`timescale 1ns / 100ps

module testbench;
    import sdf_pkg::*;

    localparam int FB = FRAC_BITS_DEF;
    localparam longint unsigned LEN_FLOOR = ((64'd1 << FB) + 64'd500000) / 64'd1000000;
    localparam int CYCLE_LIMIT = 400000;

    // The last member sits in the lowest bits, so delta_x lands in s_tdata[31:0].
    typedef struct packed {
        logic [31:0] c, r, k;
        logic signed [31:0] vz, vy, vx, dz, dy, dx;
    } spring_t;

    typedef struct packed {
        logic signed [31:0] fx, fy, fz;
        logic applied, saturated;
    } force_t;

    logic aclk = 0;
    logic aresetn = 0;
    logic s_tvalid = 0;
    logic s_tready;
    logic [9*DATA_W-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 0;
    logic [3*DATA_W-1:0] m_tdata;
    logic [1:0] m_tuser;

    spring_damper_force_top u_top (.*);

    always begin
        #5 aclk = 1;
        #5 aclk = 0;
    end

    spring_t pending_springs[$];
    force_t  expected_forces[$];
    int mismatches = 0;
    int forces_seen = 0;
    int applied_seen = 0;
    int saturated_seen = 0;
    int cycles = 0;
    bit stimulus_done = 0;

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv >>= 2;
        while (bitv != 0) begin
            if (n >= res + bitv) begin
                n -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    // Signed (a * b) >> FB truncated toward zero; magnitude held at 2^62 when huge.
    function automatic longint signed scaled_product(longint signed a, longint unsigned b,
                                                     bit bneg);
        longint unsigned m, lo, hp, q;
        m = (a < 0) ? -a : a;
        lo = (m & 64'hFFFF_FFFF) * b;
        hp = (m >> 32) * b;
        if ((hp >> (FB + 30)) != 0) q = 64'd1 << 62;
        else q = (hp << (32 - FB)) + (lo >> FB);
        return ((a < 0) != bneg) ? -longint'(q) : longint'(q);
    endfunction

    function automatic force_t spring_force(spring_t s);
        force_t f;
        longint signed d[3], v[3], u[3], dot, vel, total, fi;
        longint unsigned sq, len, q;
        d[0] = s.dx; d[1] = s.dy; d[2] = s.dz;
        v[0] = s.vx; v[1] = s.vy; v[2] = s.vz;
        sq = 0;
        dot = 0;
        f = '0;
        for (int i = 0; i < 3; i++) begin
            q = (d[i] < 0) ? -d[i] : d[i];
            sq += q * q;
        end
        len = int_sqrt(sq);
        if (len <= LEN_FLOOR) return f;
        for (int i = 0; i < 3; i++) begin
            q = (((d[i] < 0) ? -d[i] : d[i]) << FB) / len;
            u[i] = (d[i] < 0) ? -longint'(q) : longint'(q);
            dot += v[i] * u[i];
        end
        vel = (dot < 0) ? -longint'((-dot) >> FB) : (dot >> FB);
        total = scaled_product(longint'(len) - longint'({32'd0, s.r}), {32'd0, s.k}, 0)
              + scaled_product(vel, {32'd0, s.c}, 0);
        f.applied = 1;
        for (int i = 0; i < 3; i++) begin
            fi = scaled_product(total, (u[i] < 0) ? -u[i] : u[i], u[i] < 0);
            if (fi > 64'sd2147483647) begin
                fi = 64'sd2147483647;
                f.saturated = 1;
            end
            if (fi < -64'sd2147483648) begin
                fi = -64'sd2147483648;
                f.saturated = 1;
            end
            if (i == 0) f.fx = fi[31:0];
            else if (i == 1) f.fy = fi[31:0];
            else f.fz = fi[31:0];
        end
        return f;
    endfunction

    function automatic logic [31:0] rand_word(int mode);
        case (mode)
            0: return $urandom;
            1: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
            2: return 32'(signed'($urandom_range(0, 16'hFFFF)) >>> $urandom_range(0, 15));
            default: return $urandom_range(0, 32'h0010_0000);
        endcase
    endfunction

    task automatic add_spring(spring_t s);
        pending_springs.push_back(s);
        expected_forces.push_back(spring_force(s));
    endtask

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("MISMATCH %s: got %h expected %h", what, got, want);
        mismatches++;
    endtask

    // Sender: bursts of random length separated by random gaps.
    int burst_left = 0;
    int gap_left = 0;
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) void'(pending_springs.pop_front());
            if (!(s_tvalid && !s_tready)) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    s_tvalid <= 0;
                end else if (pending_springs.size() > ((s_tvalid && s_tready) ? 0 : 0)) begin
                    if (pending_springs.size() > 0) begin
                        s_tvalid <= 1;
                        s_tdata <= pending_springs[0];
                        if (burst_left <= 1) begin
                            burst_left <= $urandom_range(1, 40);
                            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
                        end else begin
                            burst_left <= burst_left - 1;
                        end
                    end
                end else begin
                    s_tvalid <= 0;
                end
            end
        end
    end

    // Receiver: stalls in patterns that change from time to time.
    int stall_mode = 0;
    always @(posedge aclk) begin
        if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 3);
        case (stall_mode)
            0: m_tready <= 1;
            1: m_tready <= $urandom_range(0, 1);
            2: m_tready <= ($urandom_range(0, 7) == 0);
            default: m_tready <= (cycles % 5) != 0;
        endcase
    end

    always @(posedge aclk) begin
        force_t want;
        force_t got;
        cycles <= cycles + 1;
        if (aresetn && m_tvalid && m_tready) begin
            got.fx = m_tdata[31:0];
            got.fy = m_tdata[63:32];
            got.fz = m_tdata[95:64];
            got.applied = m_tuser[0];
            got.saturated = m_tuser[1];
            if (expected_forces.size() == 0) begin
                report_mismatch("unexpected force_x", got.fx, 32'd0);
            end else begin
                want = expected_forces.pop_front();
                forces_seen++;
                applied_seen += int'(want.applied);
                saturated_seen += int'(want.saturated);
                if (got.fx !== want.fx) report_mismatch("force_x", got.fx, want.fx);
                if (got.fy !== want.fy) report_mismatch("force_y", got.fy, want.fy);
                if (got.fz !== want.fz) report_mismatch("force_z", got.fz, want.fz);
                if (got.applied !== want.applied)
                    report_mismatch("applied", 32'(got.applied), 32'(want.applied));
                if (got.saturated !== want.saturated)
                    report_mismatch("saturated", 32'(got.saturated), 32'(want.saturated));
            end
        end
    end

    initial begin
        spring_t s;
        int mode;
        repeat (7) @(posedge aclk);
        aresetn <= 1;

        // Directed: zero length, tiny lengths, extremes, saturation, single axes.
        add_spring('0);
        s = '0; s.dx = 1; s.k = 32'hFFFF_FFFF; add_spring(s);
        s = '0; s.dy = 2; s.k = 32'h0001_0000; add_spring(s);
        s = '0; s.dz = -32'sd65536; s.k = 32'h0001_0000; s.r = 32'h0000_8000; add_spring(s);
        s = '0; s.dx = 32'h7FFF_FFFF; s.k = 32'hFFFF_FFFF; add_spring(s);
        s = '0; s.dx = 32'h8000_0000; s.dy = 32'h8000_0000; s.dz = 32'h8000_0000;
        s.k = 32'hFFFF_FFFF; s.c = 32'hFFFF_FFFF;
        s.vx = 32'h7FFF_FFFF; s.vy = 32'h8000_0000; s.vz = 32'h7FFF_FFFF; add_spring(s);
        s = '0; s.dx = 32'h7FFF_FFFF; s.dy = 32'h7FFF_FFFF; s.dz = 32'h7FFF_FFFF;
        s.r = 32'hFFFF_FFFF; s.k = 32'hFFFF_FFFF; add_spring(s);
        s = '0; s.dy = 32'h0003_0000; s.vy = -32'sd65536 * 5; s.c = 32'h0002_0000;
        s.k = 32'h0001_0000; s.r = 32'h0003_0000; add_spring(s);
        s = '0; s.dx = 32'h0003_0000; s.dy = -32'sd262144; s.k = 32'h000A_0000;
        s.r = 32'h0002_0000; s.vx = 32'h0000_1000; s.c = 32'h0000_8000; add_spring(s);
        s = '1; add_spring(s);
        s = '0; s.dz = 32'h0100_0000; s.vz = 32'h8000_0000; s.c = 32'hFFFF_FFFF;
        add_spring(s);

        for (int n = 0; n < 1150; n++) begin
            mode = $urandom_range(0, 3);
            s.dx = rand_word(mode); s.dy = rand_word(mode); s.dz = rand_word(mode);
            s.vx = rand_word($urandom_range(0, 3));
            s.vy = rand_word($urandom_range(0, 3));
            s.vz = rand_word($urandom_range(0, 3));
            s.k = ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, 32'h0010_0000);
            s.r = ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, 32'h0004_0000);
            s.c = ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, 32'h0004_0000);
            if ($urandom_range(0, 15) == 0) begin
                s.dx = $urandom_range(0, 2) - 1;
                s.dy = $urandom_range(0, 2) - 1;
                s.dz = $urandom_range(0, 2) - 1;
            end
            add_spring(s);
        end
        stimulus_done = 1;
    end

    always @(posedge aclk) begin
        if (cycles >= CYCLE_LIMIT) begin
            $display("Timed out with %0d force transactions outstanding",
                     expected_forces.size());
            $display("spring_damper_force_top verification failed");
            $finish;
        end
    end

    initial begin
        wait (stimulus_done);
        wait (pending_springs.size() == 0 && expected_forces.size() == 0);
        repeat (100) @(posedge aclk);
        $display("Checked %0d spring forces: %0d applied, %0d short, %0d saturated.",
                 forces_seen, applied_seen, forces_seen - applied_seen, saturated_seen);
        if (mismatches == 0) begin
            $display("spring_damper_force_top verification clean");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("spring_damper_force_top verification failed");
        end
        $finish;
    end
endmodule

[filelist.f]
+incdir+hdl
hdl/sdf_pkg.sv
hdl/spring_damper_force_top.sv
hdl/sdf_checker.sv
dv/testbench.sv
